>>> rtl/gcs_pkg.sv
// Shared types and constants for the gray 3x3 convolution stream.
// Used by the stream interfaces and by the top level; depends on nothing.
package gcs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int KERNEL_DIM = 3;
  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int GRAY_W     = 10;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = 18;
  localparam int RSUM_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd5;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic        RST_COLOR_MODE   = 1'b1;
  // Laplacian: 0 1 0 / 1 -4 1 / 0 1 0 in Q4.4
  localparam logic [23:0] RST_KERNEL_TOP    = 24'h001000;
  localparam logic [23:0] RST_KERNEL_MIDDLE = 24'h10C010;
  localparam logic [23:0] RST_KERNEL_BOTTOM = 24'h001000;

  localparam logic [10:0] MIN_DIM_W = 11'd3;
  localparam logic [11:0] MIN_DIM_H = 12'd3;
  localparam logic [10:0] MAX_DIM_W = 11'(MAX_WIDTH);

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic signed [20:0] result_value;
    logic [9:0]         out_x;
    logic [11:0]        out_y;
    logic               last_result;
  } result_t;

endpackage

>>> rtl/gcs_pixel_if.sv
// Valid/ready channel carrying one input pixel item.
// Depends on gcs_pkg for the payload type.
interface gcs_pixel_if;
  logic            valid;
  logic            ready;
  gcs_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gcs_result_if.sv
// Valid/ready channel carrying one convolution result item.
// Depends on gcs_pkg for the payload type.
interface gcs_result_if;
  logic             valid;
  logic             ready;
  gcs_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gcs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/gray_conv3x3_stream.sv
// Streaming 3x3 convolution of a gray image built from raster-order pixels.
// A result passes through stage 0, the window, product and row-sum stages and the output
// register after the item completing its window is accepted.
// Throughput: one pixel item per cycle while the skid register is empty; the line-store
// RAMs are read and written once per item; the nine products and adder tree are pipelined.
// The output register plus a skid register decouple input ready from output ready.
// Reset (rst, synchronous): counters, window and valid flags clear, registers take defaults.
module gray_conv3x3_stream (
  input  logic                               clk,
  input  logic                               rst,
  gcs_pixel_if.sink                          pix,
  gcs_result_if.source                       res,
  input  logic                               cfg_we,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gcs_pkg::*;

  // Configuration
  logic [10:0]           image_width;
  logic [11:0]           image_height;
  logic                  color_mode;
  logic [CFG_DATA_W-1:0] kernel_rows [KERNEL_DIM];

  // Frame position
  logic [IDX_W-1:0] column_count;
  logic [11:0]      row_count;

  // Pipeline control
  logic en;
  logic accept;

  // Accept-side combinational values
  logic [10:0]       eff_w;
  logic [11:0]       eff_h;
  logic              end_row;
  logic              end_frame;
  logic              emit;
  logic [GRAY_W-1:0] gray;

  // Stage 0: pixel registered, line stores being read
  logic              s0_valid;
  logic              s0_emit;
  logic [IDX_W-1:0]  s0_idx;
  logic [GRAY_W-1:0] s0_gray;
  result_t           s0_meta;
  logic [GRAY_W-1:0] older_q;
  logic [GRAY_W-1:0] newer_q;

  // Stage 1: window updated
  logic              s1_valid;
  result_t           s1_meta;
  logic [GRAY_W-1:0] window_regs [KERNEL_DIM][KERNEL_DIM];

  // Stage 2: products
  logic                     s2_valid;
  result_t                  s2_meta;
  logic signed [PROD_W:0]   prod_full [KERNEL_DIM][KERNEL_DIM];
  logic signed [PROD_W-1:0] prod      [KERNEL_DIM][KERNEL_DIM];

  // Stage 3: row sums
  logic                     s3_valid;
  result_t                  s3_meta;
  logic signed [RSUM_W-1:0] rsum_next [KERNEL_DIM];
  logic signed [RSUM_W-1:0] rsum      [KERNEL_DIM];

  // Output and skid registers
  result_t total;
  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;

  assign en     = !skid_valid;
  assign accept = pix.valid && en;
  assign pix.ready = en;

  assign res.valid = out_valid;
  assign res.data  = out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      color_mode     <= RST_COLOR_MODE;
      kernel_rows[0] <= RST_KERNEL_TOP;
      kernel_rows[1] <= RST_KERNEL_MIDDLE;
      kernel_rows[2] <= RST_KERNEL_BOTTOM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width    <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT:  image_height   <= cfg_data[11:0];
        CFG_COLOR_MODE:    color_mode     <= cfg_data[0];
        CFG_KERNEL_TOP:    kernel_rows[0] <= cfg_data;
        CFG_KERNEL_MIDDLE: kernel_rows[1] <= cfg_data;
        CFG_KERNEL_BOTTOM: kernel_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry clamps, position decode and gray conversion
  always_comb begin
    if (image_width < MIN_DIM_W) begin
      eff_w = MIN_DIM_W;
    end else if (image_width > MAX_DIM_W) begin
      eff_w = MAX_DIM_W;
    end else begin
      eff_w = image_width;
    end
    eff_h     = (image_height < MIN_DIM_H) ? MIN_DIM_H : image_height;
    end_row   = {1'b0, column_count} >= (eff_w - 11'd1);
    end_frame = row_count >= (eff_h - 12'd1);
    emit      = (column_count >= IDX_W'(2)) && (row_count >= 12'd2);
    if (color_mode) begin
      gray = GRAY_W'(pix.data.pixel_red) + GRAY_W'(pix.data.pixel_green)
           + GRAY_W'(pix.data.pixel_blue);
    end else begin
      gray = {1'b0, pix.data.pixel_red, 1'b0} + GRAY_W'(pix.data.pixel_red);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (end_row) begin
        column_count <= '0;
        row_count    <= end_frame ? 12'd0 : row_count + 12'd1;
      end else begin
        column_count <= column_count + IDX_W'(1);
      end
    end
  end

  // Line stores: read at acceptance, written back as the item leaves stage 0
  gcs_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_line_store_older (
    .clk   (clk),
    .we    (s0_valid && en),
    .waddr (s0_idx),
    .wdata (newer_q),
    .re    (accept),
    .raddr (column_count),
    .rdata (older_q)
  );

  gcs_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_line_store_newer (
    .clk   (clk),
    .we    (s0_valid && en),
    .waddr (s0_idx),
    .wdata (s0_gray),
    .re    (accept),
    .raddr (column_count),
    .rdata (newer_q)
  );

  // Stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_emit                  <= emit;
      s0_idx                   <= column_count;
      s0_gray                  <= gray;
      s0_meta.result_value     <= '0;
      s0_meta.out_x            <= column_count - IDX_W'(2);
      s0_meta.out_y            <= row_count - 12'd2;
      s0_meta.last_result      <= end_row && end_frame;
    end
  end

  // Stage 1: shift the window left and load the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
          window_regs[i][j] <= '0;
        end
      end
    end else if (en) begin
      s1_valid <= s0_valid && s0_emit;
      if (s0_valid) begin
        for (int i = 0; i < KERNEL_DIM; i++) begin
          for (int j = 0; j < KERNEL_DIM - 1; j++) begin
            window_regs[i][j] <= window_regs[i][j+1];
          end
        end
        window_regs[0][KERNEL_DIM-1] <= older_q;
        window_regs[1][KERNEL_DIM-1] <= newer_q;
        window_regs[2][KERNEL_DIM-1] <= s0_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s0_valid) begin
      s1_meta <= s0_meta;
    end
  end

  // Stage 2: nine products, coefficient left column in the low byte
  always_comb begin
    for (int i = 0; i < KERNEL_DIM; i++) begin
      for (int j = 0; j < KERNEL_DIM; j++) begin
        prod_full[i][j] = $signed(kernel_rows[i][COEF_W*j +: COEF_W])
                        * $signed({1'b0, window_regs[i][j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_meta <= s1_meta;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
          prod[i][j] <= prod_full[i][j][PROD_W-1:0];
        end
      end
    end
  end

  // Stage 3: one sum per kernel row
  always_comb begin
    for (int i = 0; i < KERNEL_DIM; i++) begin
      rsum_next[i] = RSUM_W'(prod[i][0]) + RSUM_W'(prod[i][1]) + RSUM_W'(prod[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      s3_meta <= s2_meta;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        rsum[i] <= rsum_next[i];
      end
    end
  end

  always_comb begin
    total = s3_meta;
    total.result_value = 21'(rsum[0]) + 21'(rsum[1]) + 21'(rsum[2]);
  end

  // Output register with skid: park the item when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s3_valid;
      end
    end else if (s3_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (s3_valid) begin
        out_data <= total;
      end
    end else if (s3_valid && en) begin
      skid_data <= total;
    end
  end

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !pix.ready)
    else $error("input ready while the skid register is full");

  a_accept_loads_s0: assert property (@(posedge clk) disable iff (rst)
    accept |=> s0_valid)
    else $error("accepted item missing from stage 0");

  a_border_no_result: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && en && !s0_emit) |=> !s1_valid)
    else $error("border pixel produced a result");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && end_row && end_frame) |=> (column_count == '0 && row_count == '0))
    else $error("position counters did not wrap at frame end");

endmodule
